[sv/vfl_pkg.sv]
`default_nettype none
package vfl_pkg;

  // Field widths
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned BUTTONS_W  = 4;
  localparam int unsigned BAND_W     = 8;
  localparam int unsigned MEAS_W     = 32;
  localparam int unsigned FREQ_W     = 25;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned PWM_W      = 14;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned STEP_W     = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  // Item kinds
  localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_EDGE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_GATE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_SPLIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX    = 3'd5;

  // Register reset values
  localparam logic [WINDOW_W-1:0] LOCK_WINDOW_RST = 16'd100;
  localparam logic [SCALE_W-1:0]  COUNT_SCALE_RST = 16'd1600;
  localparam logic [PWM_W-1:0]    PWM_PERIOD_RST  = 14'd15000;
  localparam logic [PWM_W-1:0]    PWM_SPLIT_RST   = 14'd7500;
  localparam logic [FREQ_W-1:0]   FREQ_MIN_RST    = 25'd100000;
  localparam logic [FREQ_W-1:0]   FREQ_MAX_RST    = 25'd29000000;

  // State reset values
  localparam logic [FREQ_W-1:0] SET_FREQ_RST  = 25'd14070000;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 20'd100000;
  localparam logic [BAND_W-1:0] BAND_SEL_RST  = 8'd2;

  // Step button choices
  localparam logic [STEP_W-1:0] STEP_1M   = 20'd1000000;
  localparam logic [STEP_W-1:0] STEP_100K = 20'd100000;
  localparam logic [STEP_W-1:0] STEP_10K  = 20'd10000;
  localparam logic [STEP_W-1:0] STEP_1K   = 20'd1000;

  // Band thresholds, highest first
  localparam logic [FREQ_W-1:0] BAND_TH1 = 25'd15000000;
  localparam logic [FREQ_W-1:0] BAND_TH2 = 25'd7500000;
  localparam logic [FREQ_W-1:0] BAND_TH3 = 25'd3750000;
  localparam logic [FREQ_W-1:0] BAND_TH4 = 25'd1875000;
  localparam logic [FREQ_W-1:0] BAND_TH5 = 25'd937500;
  localparam logic [FREQ_W-1:0] BAND_TH6 = 25'd468750;
  localparam logic [FREQ_W-1:0] BAND_TH7 = 25'd234375;

endpackage
`default_nettype wire

[sv/vfl_in_if.sv]
`default_nettype none
interface vfl_in_if;
  logic                           valid;
  logic                           ready;
  logic [vfl_pkg::OPCODE_W-1:0]   opcode;
  logic [vfl_pkg::BUTTONS_W-1:0]  step_buttons;
  logic [vfl_pkg::BUTTONS_W-1:0]  adjust_buttons;

  modport source (output valid, opcode, step_buttons, adjust_buttons, input ready);
  modport sink   (input valid, opcode, step_buttons, adjust_buttons, output ready);
endinterface
`default_nettype wire

[sv/vfl_out_if.sv]
`default_nettype none
interface vfl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        pwm_low;
  logic                        pwm_high;
  logic [vfl_pkg::BAND_W-1:0]  band;
  logic                        locked;
  logic [vfl_pkg::MEAS_W-1:0]  measured_freq;
  logic [vfl_pkg::FREQ_W-1:0]  target_freq;

  modport source (output valid, pwm_low, pwm_high, band, locked, measured_freq,
                  target_freq, input ready);
  modport sink   (input valid, pwm_low, pwm_high, band, locked, measured_freq,
                  target_freq, output ready);
endinterface
`default_nettype wire

[sv/vfl_cfg_if.sv]
`default_nettype none
interface vfl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vfl_pkg::CFG_IDX_W-1:0]   index;
  logic [vfl_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/vco_frequency_lock_controller.sv]
// Oscillator frequency lock controller.
// item_in carries one beat per event: a PWM tick, an oscillator edge or a
// gate-period end (with the step and adjust buttons sampled on gates).
// result_out returns one beat per input beat: both PWM levels, the band
// select, the lock flag, the last measured and the current set frequency.
// cfg writes the six setup registers; it is always ready. The user must
// write cfg only while no beat is in flight; the block does not enforce it.
// One beat per cycle while result_out is not stalled and no edge-sum reload
// is pending. The state update for a beat happens at its accept edge; its
// result is loaded into the output register once result_out has room.
// The measured value is kept as a running sum of count_scale per edge; a
// write to count_scale reloads it from one 16x16 multiply, holding
// item_in.ready low for that one cycle.
// Reset (synchronous, rst high) loads all register defaults, sets the
// frequency to 14.07 MHz with a 100 kHz step and empties the pipeline.
// When result_out stalls, one more beat is taken into the state stage and
// then item_in.ready drops until the output register is read.
`default_nettype none
module vco_frequency_lock_controller (
  input  wire logic  clk,
  input  wire logic  rst,
  vfl_in_if.sink     item_in,
  vfl_out_if.source  result_out,
  vfl_cfg_if.sink    cfg
);

  // Setup registers
  logic [vfl_pkg::WINDOW_W-1:0] lock_window;
  logic [vfl_pkg::SCALE_W-1:0]  count_scale;
  logic [vfl_pkg::PWM_W-1:0]    pwm_period;
  logic [vfl_pkg::PWM_W-1:0]    pwm_split;
  logic [vfl_pkg::FREQ_W-1:0]   freq_min;
  logic [vfl_pkg::FREQ_W-1:0]   freq_max;

  // Block state
  logic [vfl_pkg::PWM_W-1:0]    tick_count;
  logic [vfl_pkg::EDGE_W-1:0]   edge_count;
  logic [vfl_pkg::MEAS_W-1:0]   edge_sum;
  logic                         sum_stale;
  logic [vfl_pkg::MEAS_W-1:0]   measured;
  logic [vfl_pkg::PWM_W-1:0]    duty_low;
  logic [vfl_pkg::PWM_W-1:0]    duty_high;
  logic                         lock_flag;
  logic [vfl_pkg::FREQ_W-1:0]   set_freq;
  logic [vfl_pkg::STEP_W-1:0]   step_size;
  logic [vfl_pkg::BAND_W-1:0]   band_sel;
  logic                         state_pend;
  logic                         out_valid;

  logic in_take;
  logic pend_move;
  logic cfg_take;

  // Next values of the gate path
  logic [vfl_pkg::PWM_W:0]      tick_inc;
  logic [vfl_pkg::PWM_W-1:0]    tick_next;
  logic signed [33:0]           err_s;
  logic [32:0]                  err_abs;
  logic                         lock_next;
  logic signed [33:0]           drive_s;
  logic signed [33:0]           split_s;
  logic signed [33:0]           excess_s;
  logic [vfl_pkg::PWM_W-1:0]    duty_low_next;
  logic [vfl_pkg::PWM_W-1:0]    duty_high_next;
  logic [vfl_pkg::BAND_W-1:0]   band_next;
  logic [vfl_pkg::STEP_W-1:0]   step_next;
  logic signed [23:0]           step_s;
  logic signed [23:0]           delta;
  logic signed [26:0]           nf;
  logic [vfl_pkg::FREQ_W-1:0]   set_next;

  function automatic logic [vfl_pkg::PWM_W-1:0] clamp_duty(
    input logic signed [33:0]       v,
    input logic [vfl_pkg::PWM_W-1:0] period
  );
    logic [vfl_pkg::PWM_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({20'b0, period})) begin
      r = period;
    end else begin
      r = v[vfl_pkg::PWM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [vfl_pkg::BAND_W-1:0] pick_band(
    input logic [vfl_pkg::FREQ_W-1:0] f
  );
    logic [vfl_pkg::BAND_W-1:0] b;
    if (f > vfl_pkg::BAND_TH1)      b = 8'd1;
    else if (f > vfl_pkg::BAND_TH2) b = 8'd2;
    else if (f > vfl_pkg::BAND_TH3) b = 8'd4;
    else if (f > vfl_pkg::BAND_TH4) b = 8'd8;
    else if (f > vfl_pkg::BAND_TH5) b = 8'd16;
    else if (f > vfl_pkg::BAND_TH6) b = 8'd32;
    else if (f > vfl_pkg::BAND_TH7) b = 8'd64;
    else                            b = 8'd128;
    return b;
  endfunction

  // Handshakes
  assign pend_move     = state_pend && (!out_valid || result_out.ready);
  assign item_in.ready = !sum_stale && (!state_pend || pend_move);
  assign in_take       = item_in.valid && item_in.ready;
  assign cfg.ready     = 1'b1;
  assign cfg_take      = cfg.valid;

  // Tick counter advance
  always_comb begin
    tick_inc  = {1'b0, tick_count} + 15'd1;
    tick_next = (tick_inc >= {1'b0, pwm_period}) ? '0 : tick_inc[vfl_pkg::PWM_W-1:0];
  end

  // Lock test and PWM drive from the running edge sum; band from the set frequency
  always_comb begin
    err_s     = $signed({9'b0, set_freq}) - $signed({2'b0, edge_sum});
    err_abs   = err_s[33] ? 33'(-err_s) : err_s[32:0];
    lock_next = err_abs < {17'b0, lock_window};
    drive_s   = $signed({9'b0, set_freq}) - $signed({3'b0, edge_sum[31:1]});
    split_s   = $signed({20'b0, pwm_split});
    excess_s  = drive_s - split_s;
    if (drive_s > split_s) begin
      duty_low_next  = clamp_duty(split_s, pwm_period);
      duty_high_next = clamp_duty(excess_s, pwm_period);
    end else begin
      duty_low_next  = clamp_duty(drive_s, pwm_period);
      duty_high_next = '0;
    end
    band_next = pick_band(set_freq);
  end

  // Step select (later buttons override) and set frequency adjust
  always_comb begin
    step_next = step_size;
    if (item_in.step_buttons[0]) step_next = vfl_pkg::STEP_1M;
    if (item_in.step_buttons[1]) step_next = vfl_pkg::STEP_100K;
    if (item_in.step_buttons[2]) step_next = vfl_pkg::STEP_10K;
    if (item_in.step_buttons[3]) step_next = vfl_pkg::STEP_1K;
    step_s = $signed({4'b0, step_next});
    delta  = '0;
    if (item_in.adjust_buttons[0]) delta = delta + step_s;
    if (item_in.adjust_buttons[1]) delta = delta + (step_s <<< 1);
    if (item_in.adjust_buttons[2]) delta = delta - step_s;
    if (item_in.adjust_buttons[3]) delta = delta - (step_s <<< 1);
    nf = $signed({2'b0, set_freq}) + 27'(delta);
    if (nf < $signed({2'b0, freq_min})) nf = $signed({2'b0, freq_min});
    if (nf > $signed({2'b0, freq_max})) nf = $signed({2'b0, freq_max});
    set_next = nf[vfl_pkg::FREQ_W-1:0];
  end

  // Setup register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_window <= vfl_pkg::LOCK_WINDOW_RST;
      count_scale <= vfl_pkg::COUNT_SCALE_RST;
      pwm_period  <= vfl_pkg::PWM_PERIOD_RST;
      pwm_split   <= vfl_pkg::PWM_SPLIT_RST;
      freq_min    <= vfl_pkg::FREQ_MIN_RST;
      freq_max    <= vfl_pkg::FREQ_MAX_RST;
    end else if (cfg_take) begin
      unique case (cfg.index)
        vfl_pkg::REG_LOCK_WINDOW: lock_window <= cfg.data[vfl_pkg::WINDOW_W-1:0];
        vfl_pkg::REG_COUNT_SCALE: count_scale <= cfg.data[vfl_pkg::SCALE_W-1:0];
        vfl_pkg::REG_PWM_PERIOD:  pwm_period  <= cfg.data[vfl_pkg::PWM_W-1:0];
        vfl_pkg::REG_PWM_SPLIT:   pwm_split   <= cfg.data[vfl_pkg::PWM_W-1:0];
        vfl_pkg::REG_FREQ_MIN:    freq_min    <= cfg.data[vfl_pkg::FREQ_W-1:0];
        vfl_pkg::REG_FREQ_MAX:    freq_max    <= cfg.data[vfl_pkg::FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Apply one beat to the state; reload the edge sum after a scale change
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      edge_count <= '0;
      edge_sum   <= '0;
      sum_stale  <= 1'b0;
      measured   <= '0;
      duty_low   <= '0;
      duty_high  <= '0;
      lock_flag  <= 1'b0;
      set_freq   <= vfl_pkg::SET_FREQ_RST;
      step_size  <= vfl_pkg::STEP_SIZE_RST;
      band_sel   <= vfl_pkg::BAND_SEL_RST;
    end else begin
      sum_stale <= cfg_take && (cfg.index == vfl_pkg::REG_COUNT_SCALE);
      if (sum_stale) begin
        edge_sum <= 32'({16'b0, edge_count} * {16'b0, count_scale});
      end
      if (in_take) begin
        case (item_in.opcode)
          vfl_pkg::OP_TICK: begin
            tick_count <= tick_next;
          end
          vfl_pkg::OP_EDGE: begin
            if (edge_count != '1) begin
              edge_count <= edge_count + 16'd1;
              edge_sum   <= edge_sum + {16'b0, count_scale};
            end
          end
          vfl_pkg::OP_GATE: begin
            measured   <= edge_sum;
            edge_count <= '0;
            edge_sum   <= '0;
            lock_flag  <= lock_next;
            duty_low   <= duty_low_next;
            duty_high  <= duty_high_next;
            band_sel   <= band_next;
            step_size  <= step_next;
            set_freq   <= set_next;
          end
          default: ;
        endcase
      end
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        state_pend <= 1'b1;
      end else if (pend_move) begin
        state_pend <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output register from the state
  always_ff @(posedge clk) begin
    if (pend_move) begin
      result_out.pwm_low       <= tick_count < duty_low;
      result_out.pwm_high      <= tick_count < duty_high;
      result_out.band          <= band_sel;
      result_out.locked        <= lock_flag;
      result_out.measured_freq <= measured;
      result_out.target_freq   <= set_freq;
    end
  end

  assign result_out.valid = out_valid;

  // Checks
  a_stale_blocks_input: assert property (@(posedge clk) disable iff (rst)
    sum_stale |-> !item_in.ready)
    else $error("input taken while edge sum reloads");

  a_sum_matches: assert property (@(posedge clk) disable iff (rst)
    !sum_stale |-> edge_sum == 32'({16'b0, edge_count} * {16'b0, count_scale}))
    else $error("running edge sum out of step with edge count");

  a_band_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(band_sel))
    else $error("band select not one-hot");

  a_pend_drains: assert property (@(posedge clk) disable iff (rst)
    state_pend && (!out_valid || result_out.ready) |=> out_valid)
    else $error("pending result not moved to output");

  a_edge_saturates: assert property (@(posedge clk) disable iff (rst)
    in_take && item_in.opcode == vfl_pkg::OP_EDGE && edge_count == '1
    |=> edge_count == '1)
    else $error("edge counter wrapped");

endmodule
`default_nettype wire

[sim/tb_vco_frequency_lock_controller.sv]
`timescale 1ns / 1ps
module tb_vco_frequency_lock_controller;
  import vfl_pkg::*;

  // Opcode with no meaning to the block: state must hold
  localparam logic [OPCODE_W-1:0] OP_SKIP = 2'd3;
  // Quiet cycles after the last result before a register write
  localparam int unsigned SETTLE_CYC = 3;

  typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN} ent_kind_t;

  typedef struct {
    ent_kind_t              kind;
    logic [OPCODE_W-1:0]    opcode;
    logic [BUTTONS_W-1:0]   steps;
    logic [BUTTONS_W-1:0]   adjust;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     rush;
  } stim_ent_t;

  typedef struct packed {
    logic               pwm_low;
    logic               pwm_high;
    logic [BAND_W-1:0]  band;
    logic               locked;
    logic [MEAS_W-1:0]  meas;
    logic [FREQ_W-1:0]  target;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vfl_in_if  item_if ();
  vfl_out_if res_if ();
  vfl_cfg_if cfg_if ();

  vco_frequency_lock_controller DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (res_if),
    .cfg        (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    item_if.valid          = 1'b0;
    item_if.opcode         = '0;
    item_if.step_buttons   = '0;
    item_if.adjust_buttons = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    res_if.ready           = 1'b0;
  end

  // Lock controller shadow: registers
  logic [WINDOW_W-1:0] r_win    = LOCK_WINDOW_RST;
  logic [SCALE_W-1:0]  r_scale  = COUNT_SCALE_RST;
  logic [PWM_W-1:0]    r_period = PWM_PERIOD_RST;
  logic [PWM_W-1:0]    r_split  = PWM_SPLIT_RST;
  logic [FREQ_W-1:0]   r_fmin   = FREQ_MIN_RST;
  logic [FREQ_W-1:0]   r_fmax   = FREQ_MAX_RST;

  // Lock controller shadow: state
  logic [PWM_W-1:0]    m_tick    = '0;
  logic [EDGE_W-1:0]   m_edges   = '0;
  logic [MEAS_W-1:0]   m_meas    = '0;
  logic [PWM_W-1:0]    m_duty_lo = '0;
  logic [PWM_W-1:0]    m_duty_hi = '0;
  logic                m_lock    = 1'b0;
  logic [FREQ_W-1:0]   m_set     = SET_FREQ_RST;
  logic [STEP_W-1:0]   m_step    = STEP_SIZE_RST;
  logic [BAND_W-1:0]   m_band    = BAND_SEL_RST;

  stim_ent_t   stim_q[$];
  readout_t    readout_q[$];
  int unsigned err_cnt = 0;

  // Handshake flags seen at the last rising edge
  bit in_beat = 1'b0;
  bit cfg_beat = 1'b0;
  bit out_beat = 1'b0;

  // Driver and receiver pacing
  bit          busy = 1'b0;
  bit          rush_on = 1'b0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  bit          in_vld_nxt, cfg_vld_nxt;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned settle_cnt = 0;
  readout_t    got, want;

  function automatic int unsigned draw_wait(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [PWM_W-1:0] clamp_duty(longint v);
    longint top;
    top = 64'(r_period);
    if (v < 0) return '0;
    if (v > top) return r_period;
    return v[PWM_W-1:0];
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_LOCK_WINDOW: r_win    = d[WINDOW_W-1:0];
      REG_COUNT_SCALE: r_scale  = d[SCALE_W-1:0];
      REG_PWM_PERIOD:  r_period = d[PWM_W-1:0];
      REG_PWM_SPLIT:   r_split  = d[PWM_W-1:0];
      REG_FREQ_MIN:    r_fmin   = d[FREQ_W-1:0];
      REG_FREQ_MAX:    r_fmax   = d[FREQ_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow by one beat and return the readout it should produce
  function automatic readout_t predict_readout(logic [OPCODE_W-1:0] op,
                                               logic [BUTTONS_W-1:0] steps,
                                               logic [BUTTONS_W-1:0] adjust);
    longint   s, m, err, drive, nf, win, split, stp, lo, hi;
    int       lvl;
    readout_t r;
    case (op)
      OP_TICK: m_tick = ({1'b0, m_tick} + 15'd1 >= {1'b0, r_period}) ? '0 : m_tick + 14'd1;
      OP_EDGE: if (m_edges != '1) m_edges = m_edges + 16'd1;
      OP_GATE: begin
        m_meas  = 32'(m_edges) * 32'(r_scale);
        m_edges = '0;
        s = 64'(m_set);
        m = 64'(m_meas);
        win = 64'(r_win);
        split = 64'(r_split);
        err = s - m;
        if (err < 0) err = -err;
        m_lock = (err < win);
        // Split the drive across the two channels
        drive = s - m / 2;
        if (drive > split) begin
          m_duty_lo = clamp_duty(split);
          m_duty_hi = clamp_duty(drive - split);
        end else begin
          m_duty_lo = clamp_duty(drive);
          m_duty_hi = '0;
        end
        // Band from the frequency before this gate's adjustment
        if (m_set > BAND_TH1) lvl = 0;
        else if (m_set > BAND_TH2) lvl = 1;
        else if (m_set > BAND_TH3) lvl = 2;
        else if (m_set > BAND_TH4) lvl = 3;
        else if (m_set > BAND_TH5) lvl = 4;
        else if (m_set > BAND_TH6) lvl = 5;
        else if (m_set > BAND_TH7) lvl = 6;
        else lvl = 7;
        m_band = 8'd1 << lvl;
        // Later step buttons override earlier ones
        if (steps[0]) m_step = STEP_1M;
        if (steps[1]) m_step = STEP_100K;
        if (steps[2]) m_step = STEP_10K;
        if (steps[3]) m_step = STEP_1K;
        stp = 64'(m_step);
        lo = 64'(r_fmin);
        hi = 64'(r_fmax);
        nf = s;
        if (adjust[0]) nf = nf + stp;
        if (adjust[1]) nf = nf + 2 * stp;
        if (adjust[2]) nf = nf - stp;
        if (adjust[3]) nf = nf - 2 * stp;
        if (nf < lo) nf = lo;
        if (nf > hi) nf = hi;
        if (nf < 0) nf = 0;
        m_set = nf[FREQ_W-1:0];
      end
      default: ;
    endcase
    r.pwm_low  = (m_tick < m_duty_lo);
    r.pwm_high = (m_tick < m_duty_hi);
    r.band     = m_band;
    r.locked   = m_lock;
    r.meas     = m_meas;
    r.target   = m_set;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    in_beat  = 1'b0;
    cfg_beat = 1'b0;
    out_beat = 1'b0;
    if (!rst) begin
      out_beat = res_if.valid && res_if.ready;
      if (out_beat) begin
        got = '{res_if.pwm_low, res_if.pwm_high, res_if.band, res_if.locked,
                res_if.measured_freq, res_if.target_freq};
        if (readout_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: readout mismatch, expected none, actual %h", $time, got);
        end else begin
          want = readout_q.pop_front();
          check_field("pwm_low", 64'(want.pwm_low), 64'(got.pwm_low));
          check_field("pwm_high", 64'(want.pwm_high), 64'(got.pwm_high));
          check_field("band", 64'(want.band), 64'(got.band));
          check_field("locked", 64'(want.locked), 64'(got.locked));
          check_field("measured_freq", 64'(want.meas), 64'(got.meas));
          check_field("target_freq", 64'(want.target), 64'(got.target));
        end
      end
      if (item_if.valid && item_if.ready) begin
        in_beat = 1'b1;
        readout_q.push_back(predict_readout(item_if.opcode, item_if.step_buttons,
                                            item_if.adjust_buttons));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        cfg_beat = 1'b1;
        apply_reg(cfg_if.index, cfg_if.data);
      end
    end
  end

  // Feed items and register writes from the pending queue
  always @(negedge clk) begin
    if (!rst) begin
      in_vld_nxt  = item_if.valid;
      cfg_vld_nxt = cfg_if.valid;
      if (in_beat) begin
        in_vld_nxt = 1'b0;
        busy = 1'b0;
        gap_left = draw_wait(calm_in || rush_on);
      end
      if (cfg_beat) begin
        cfg_vld_nxt = 1'b0;
        busy = 1'b0;
      end
      if (!busy && gap_left > 0) begin
        gap_left--;
      end else if (!busy && stim_q.size() > 0) begin
        case (stim_q[0].kind)
          ENT_ITEM: begin
            item_if.opcode         <= stim_q[0].opcode;
            item_if.step_buttons   <= stim_q[0].steps;
            item_if.adjust_buttons <= stim_q[0].adjust;
            in_vld_nxt = 1'b1;
            rush_on = stim_q[0].rush;
            busy = 1'b1;
            if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
            void'(stim_q.pop_front());
          end
          ENT_CFG: begin
            cfg_if.index <= stim_q[0].idx;
            cfg_if.data  <= stim_q[0].data;
            cfg_vld_nxt = 1'b1;
            busy = 1'b1;
            void'(stim_q.pop_front());
          end
          default: begin
            // Hold until every readout is back, then let the block settle
            if (readout_q.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt >= SETTLE_CYC) begin
              settle_cnt = 0;
              void'(stim_q.pop_front());
            end else begin
              settle_cnt++;
            end
          end
        endcase
      end
      item_if.valid <= in_vld_nxt;
      cfg_if.valid  <= cfg_vld_nxt;
    end
  end

  // Receiver: stall a random number of cycles before each beat
  always @(negedge clk) begin
    if (!rst) begin
      if (out_beat) begin
        if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
        stall_left = draw_wait(calm_out || rush_on);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic [OPCODE_W-1:0] op, logic [BUTTONS_W-1:0] st,
                           logic [BUTTONS_W-1:0] adj, bit rush);
    stim_ent_t e;
    e.kind = ENT_ITEM;
    e.opcode = op;
    e.steps = st;
    e.adjust = adj;
    e.idx = '0;
    e.data = '0;
    e.rush = rush;
    stim_q.push_back(e);
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned d);
    stim_ent_t e;
    e.kind = ENT_CFG;
    e.opcode = '0;
    e.steps = '0;
    e.adjust = '0;
    e.idx = idx;
    e.data = d[CFG_DATA_W-1:0];
    e.rush = 1'b0;
    stim_q.push_back(e);
  endtask

  // Drain the block, then load all six registers
  task automatic write_setup(int unsigned win, int unsigned sc, int unsigned per,
                             int unsigned sp, int unsigned fmin, int unsigned fmax);
    stim_ent_t e;
    e.kind = ENT_DRAIN;
    e.opcode = '0;
    e.steps = '0;
    e.adjust = '0;
    e.idx = '0;
    e.data = '0;
    e.rush = 1'b0;
    stim_q.push_back(e);
    push_cfg(REG_LOCK_WINDOW, win);
    push_cfg(REG_COUNT_SCALE, sc);
    push_cfg(REG_PWM_PERIOD, per);
    push_cfg(REG_PWM_SPLIT, sp);
    push_cfg(REG_FREQ_MIN, fmin);
    push_cfg(REG_FREQ_MAX, fmax);
  endtask

  // One measurement: shuffled edges and ticks with some noise, closed by a gate
  task automatic queue_round(int unsigned n_edge, int unsigned n_tick, ref int unsigned cnt);
    int unsigned e_left, t_left;
    e_left = n_edge;
    t_left = n_tick;
    while (e_left + t_left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 1'b0);
      end else if (e_left > 0 &&
                   (t_left == 0 || $urandom_range(0, e_left + t_left - 1) < e_left)) begin
        push_item(OP_EDGE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);
        e_left--;
      end else begin
        push_item(OP_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);
        t_left--;
      end
      cnt++;
    end
    push_item(OP_GATE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);
    cnt++;
  endtask

  // Build the stimulus, release reset, wait for the end
  initial begin
    int unsigned cnt, sc, n, f, p, sp, ne, nt;

    // Directed: reset setup, every opcode and every button
    push_item(OP_SKIP, 4'hF, 4'hF, 1'b0);
    push_item(OP_TICK, 4'h0, 4'h0, 1'b0);
    push_item(OP_TICK, 4'hF, 4'hF, 1'b0);
    repeat (3) push_item(OP_EDGE, 4'h0, 4'h0, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h0, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h1, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h2, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h4, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h8, 1'b0);
    push_item(OP_GATE, 4'h1, 4'h2, 1'b0);
    push_item(OP_GATE, 4'h2, 4'h1, 1'b0);
    push_item(OP_GATE, 4'h4, 4'h4, 1'b0);
    push_item(OP_GATE, 4'h8, 4'h8, 1'b0);
    push_item(OP_GATE, 4'hF, 4'hF, 1'b0);
    // Climb into the upper frequency clamp
    repeat (6) push_item(OP_GATE, 4'h1, 4'h3, 1'b0);
    push_item(OP_TICK, 4'h0, 4'h0, 1'b0);

    // Zero period: counter pinned at zero, duties clamp to zero
    write_setup(100, 1600, 0, 7500, 100000, 29000000);
    repeat (3) push_item(OP_TICK, 4'h0, 4'h0, 1'b0);
    push_item(OP_EDGE, 4'h0, 4'h0, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h0, 1'b0);
    push_item(OP_TICK, 4'h0, 4'h0, 1'b0);

    // Minimum above maximum: the maximum clamp wins
    write_setup(100, 1600, 15000, 7500, 20000000, 5000000);
    push_item(OP_GATE, 4'h0, 4'h0, 1'b0);
    push_item(OP_GATE, 4'h0, 4'h1, 1'b0);

    // Full-rate edge burst at the widest setup
    write_setup(65535, 65535, 16383, 16383, 0, 33554431);
    repeat (40) push_item(OP_EDGE, 4'h0, 4'h0, 1'b1);
    push_item(OP_GATE, 4'h0, 4'h0, 1'b0);
    push_item(OP_TICK, 4'h0, 4'h0, 1'b0);

    // Lock hunting: pinned set frequency near a multiple of the scale
    sc = $urandom_range(1000, 65535);
    n = $urandom_range(1, 12);
    f = n * sc + $urandom_range(0, 200);
    f = (f > 100) ? f - 100 : f;
    write_setup($urandom_range(0, 300), sc, $urandom_range(1, 16383),
                $urandom_range(0, 16383), f, f);
    cnt = 0;
    while (cnt < 80) queue_round(n - 1 + $urandom_range(0, 2), $urandom_range(0, 4), cnt);

    // PWM sweep: short period, drive around the split point
    p = $urandom_range(1, 40);
    sp = $urandom_range(0, p + 4);
    sc = $urandom_range(4, 20);
    f = $urandom_range(0, 2 * (p + sp) + 20);
    write_setup($urandom_range(0, 65535), sc, p, sp, f, f);
    ne = (2 * f / sc + 4 > 60) ? 60 : 2 * f / sc + 4;
    nt = (2 * p > 24) ? 24 : 2 * p;
    cnt = 0;
    while (cnt < 110) queue_round($urandom_range(0, ne), $urandom_range(0, nt), cnt);

    // Full frequency range, zero window, widest PWM
    write_setup(0, 65535, 16383, 16383, 0, 33554431);
    cnt = 0;
    while (cnt < 60) queue_round($urandom_range(0, 8), $urandom_range(0, 4), cnt);
    repeat (12) push_item(OP_GATE, 4'h1, 4'h3, 1'b0);
    repeat (12) push_item(OP_GATE, 4'h1, 4'hC, 1'b0);

    // Random setups with noise items
    repeat (2) begin
      write_setup($urandom_range(0, 65535), $urandom_range(1, 65535),
                  $urandom_range(1, 16383), $urandom_range(0, 16383),
                  $urandom_range(0, 33554431), $urandom_range(0, 33554431));
      repeat (70) begin
        push_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 1'b0);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (stim_q.size() == 0 && !busy);
    wait (readout_q.size() == 0);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
